### rtl/core/hmac_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the humidity moving average check core.
// No dependencies; imported by every module of the core.
package hmac_pkg;

    localparam int RAW_W       = 16;
    localparam int HUM_W       = 7;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 7;

    localparam int HUM_MAX        = 118;
    localparam int WINDOW_DEFAULT = 4;

    localparam int CONV_MUL_W = 7;
    localparam logic [CONV_MUL_W-1:0] CONV_MUL    = 7'd125;
    localparam int                    CONV_SHIFT  = 16;
    localparam logic [HUM_W-1:0]      CONV_OFFSET = 7'd6;

    localparam logic [HUM_W-1:0] MIN_RESET = 7'd5;
    localparam logic [HUM_W-1:0] MAX_RESET = 7'd95;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_HUMIDITY = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_HUMIDITY = 8'd1;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_ZERO  = 2'd2;

    typedef struct packed {
        logic [HUM_W-1:0] min_humidity;
        logic [HUM_W-1:0] max_humidity;
    } bounds_t;

endpackage

### rtl/core/humidity_moving_average_check_core.sv
`timescale 1ns / 1ps
// Humidity moving average and range check core: top level, handshakes and bounds.
// Depends on hmac_pkg, hmac_convert, hmac_window and hmac_check.
//
// Takes one raw sensor sample per cycle and returns one result per sample, in order.
// A sample passes three register stages: the input register, the window stage
// (conversion to percent and running-sum update of the WINDOW-entry shift line)
// and the result register (average by reciprocal multiply, bound check, change
// flag). Throughput is one transaction per cycle while m_ready is high; stalls
// propagate back to s_ready stage by stage. The bounds are written over the cfg
// port (index 0 minimum, index 1 maximum, other indexes ignored); the user must
// write them only while the core is idle, which the core itself does not enforce.
module humidity_moving_average_check_core import hmac_pkg::*; #(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [RAW_W-1:0]       s_raw_sample,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [HUM_W-1:0]       m_humidity,
    output logic [STATUS_W-1:0]    m_status,
    output logic                   m_changed,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SUM_W = $clog2(WINDOW * HUM_MAX + 1);

    bounds_t          bounds_reg;
    logic             in_valid_reg;
    logic [RAW_W-1:0] raw_reg;
    logic             win_valid_reg;
    logic             out_valid_reg;

    logic             out_load;
    logic             win_load;
    logic             in_load;
    logic [HUM_W-1:0] value;
    logic [SUM_W-1:0] sum;
    status_t          status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounds_reg.min_humidity <= MIN_RESET;
            bounds_reg.max_humidity <= MAX_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MIN_HUMIDITY: bounds_reg.min_humidity <= cfg_data;
                REG_MAX_HUMIDITY: bounds_reg.max_humidity <= cfg_data;
                default: ;
            endcase
        end
    end

    // advance each stage when the one behind it can take the transaction
    assign out_load = !out_valid_reg || m_ready;
    assign win_load = !win_valid_reg || out_load;
    assign in_load  = !in_valid_reg || win_load;
    assign s_ready  = in_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            win_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_load) begin
                in_valid_reg <= s_valid;
            end
            if (win_load) begin
                win_valid_reg <= in_valid_reg;
            end
            if (out_load) begin
                out_valid_reg <= win_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load && s_valid) begin
            raw_reg <= s_raw_sample;
        end
    end

    hmac_convert u_convert (
        .raw_sample (raw_reg),
        .value      (value)
    );

    hmac_window #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (win_load && in_valid_reg),
        .value   (value),
        .sum     (sum)
    );

    hmac_check #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load && win_valid_reg),
        .sum      (sum),
        .bounds   (bounds_reg),
        .humidity (m_humidity),
        .status   (status),
        .changed  (m_changed)
    );

    assign m_status = status;
    assign m_valid  = out_valid_reg;

endmodule

### rtl/core/hmac_convert.sv
`timescale 1ns / 1ps
// Raw sensor sample to percent relative humidity, clamped at zero.
// Depends on hmac_pkg.
module hmac_convert import hmac_pkg::*; (
    input  logic [RAW_W-1:0] raw_sample,
    output logic [HUM_W-1:0] value
);

    logic [RAW_W+CONV_MUL_W-1:0] product;
    logic [HUM_W-1:0]            pct;

    assign product = raw_sample * CONV_MUL;
    assign pct     = product[CONV_SHIFT +: HUM_W];
    assign value   = (pct > CONV_OFFSET) ? (pct - CONV_OFFSET) : '0;

endmodule

### rtl/core/hmac_window.sv
`timescale 1ns / 1ps
// Sliding window of converted samples with its running sum.
// Depends on hmac_pkg.
module hmac_window import hmac_pkg::*; #(
    parameter int WINDOW = WINDOW_DEFAULT,
    parameter int SUM_W  = $clog2(WINDOW * HUM_MAX + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  logic [HUM_W-1:0] value,
    output logic [SUM_W-1:0] sum
);

    logic [HUM_W-1:0] tap_reg [WINDOW];
    logic [HUM_W-1:0] tap_next [WINDOW];
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    always_comb begin
        tap_next[0] = value;
        for (int i = 1; i < WINDOW; i++) begin
            tap_next[i] = tap_reg[i-1];
        end
        sum_next = sum_reg - SUM_W'(tap_reg[WINDOW-1]) + SUM_W'(value);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                tap_reg[i] <= '0;
            end
            sum_reg <= '0;
        end else if (load) begin
            tap_reg <= tap_next;
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

### rtl/core/hmac_check.sv
`timescale 1ns / 1ps
// Window average by reciprocal multiply, range check and change detect,
// with the result register. Depends on hmac_pkg.
module hmac_check import hmac_pkg::*; #(
    parameter int WINDOW = WINDOW_DEFAULT,
    parameter int SUM_W  = $clog2(WINDOW * HUM_MAX + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  logic [SUM_W-1:0] sum,
    input  bounds_t          bounds,
    output logic [HUM_W-1:0] humidity,
    output status_t          status,
    output logic             changed
);

    localparam int DIV_L = $clog2(WINDOW);
    localparam int DIV_S = SUM_W + DIV_L;
    localparam logic [DIV_S-1:0] DIV_M = DIV_S'(((1 << DIV_S) + WINDOW - 1) / WINDOW);

    logic [SUM_W+DIV_S-1:0] product;
    logic [HUM_W-1:0]       avg;
    status_t                status_c;
    logic                   changed_c;

    logic [HUM_W-1:0] last_reported_reg;
    logic [HUM_W-1:0] humidity_reg;
    status_t          status_reg;
    logic             changed_reg;

    always_comb begin
        product = sum * DIV_M;
        avg     = product[DIV_S +: HUM_W];
        if (avg < bounds.min_humidity || avg > bounds.max_humidity) begin
            status_c = ST_RANGE;
        end else if (avg == '0) begin
            status_c = ST_ZERO;
        end else begin
            status_c = ST_OK;
        end
        changed_c = (status_c == ST_OK) && (avg != last_reported_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reported_reg <= '0;
        end else if (load && changed_c) begin
            last_reported_reg <= avg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            humidity_reg <= avg;
            status_reg   <= status_c;
            changed_reg  <= changed_c;
        end
    end

    assign humidity = humidity_reg;
    assign status   = status_reg;
    assign changed  = changed_reg;

endmodule
